/* rtl/gla_pkg.sv */
package gla_pkg;

  // Field and store sizes.
  localparam int MAX_DEGREE = 8;
  localparam int DATA_W     = MAX_DEGREE;
  localparam int ADDR_W     = MAX_DEGREE;
  localparam int DEPTH      = 1 << MAX_DEGREE;
  localparam int DEG_W      = 4;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_BUILD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POWER = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOG   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DEGREE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_CUSTOM  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CUSTOM_POLY = 2'd2;

  // Write controls for the two table stores.
  typedef struct packed {
    logic              pwr_we;
    logic [ADDR_W-1:0] pwr_addr;
    logic [DATA_W-1:0] pwr_data;
    logic              log_we;
    logic [ADDR_W-1:0] log_addr;
    logic [DATA_W-1:0] log_data;
  } gla_wr_t;

  // Built-in feedback taps p0..p(m-1) of the primitive polynomial for degree m.
  function automatic logic [DATA_W-1:0] default_taps(input logic [DEG_W-1:0] m);
    logic [DATA_W-1:0] taps;
    case (m)
      4'd2:    taps = DATA_W'(8'h03);
      4'd3:    taps = DATA_W'(8'h03);
      4'd4:    taps = DATA_W'(8'h03);
      4'd5:    taps = DATA_W'(8'h05);
      4'd6:    taps = DATA_W'(8'h03);
      4'd7:    taps = DATA_W'(8'h03);
      4'd8:    taps = DATA_W'(8'h71);
      default: taps = '0;
    endcase
    return taps;
  endfunction

endpackage

/* rtl/gla_in_if.sv */
interface gla_in_if;
  logic                      valid;
  logic                      ready;
  logic [gla_pkg::CMD_W-1:0] cmd;
  logic [7:0]                operand;

  modport source (output valid, output cmd, output operand, input ready);
  modport sink   (input valid, input cmd, input operand, output ready);
endinterface

/* rtl/gla_out_if.sv */
interface gla_out_if;
  logic                       valid;
  logic                       ready;
  logic [gla_pkg::DATA_W-1:0] result_value;
  logic                       log_of_zero;
  logic                       out_of_range;
  logic                       tables_ready;

  modport source (output valid, output result_value, output log_of_zero,
                  output out_of_range, output tables_ready, input ready);
  modport sink   (input valid, input result_value, input log_of_zero,
                  input out_of_range, input tables_ready, output ready);
endinterface

/* rtl/gla_stores.sv */
module gla_stores (
  input  logic                        clk,
  input  gla_pkg::gla_wr_t            wr,
  input  logic [gla_pkg::ADDR_W-1:0]  rd_addr,
  output logic [gla_pkg::DATA_W-1:0]  pwr_rdata,
  output logic [gla_pkg::DATA_W-1:0]  log_rdata
);

  logic [gla_pkg::DATA_W-1:0] pwr_mem [gla_pkg::DEPTH];
  logic [gla_pkg::DATA_W-1:0] log_mem [gla_pkg::DEPTH];
  logic [gla_pkg::DATA_W-1:0] pwr_rdata_r;
  logic [gla_pkg::DATA_W-1:0] log_rdata_r;

  // Power store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr.pwr_we) begin
      pwr_mem[wr.pwr_addr] <= wr.pwr_data;
    end
    pwr_rdata_r <= pwr_mem[rd_addr];
  end

  // Log store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr.log_we) begin
      log_mem[wr.log_addr] <= wr.log_data;
    end
    log_rdata_r <= log_mem[rd_addr];
  end

  assign pwr_rdata = pwr_rdata_r;
  assign log_rdata = log_rdata_r;

endmodule

/* rtl/gf2m_log_antilog_table_builder_core.sv */
// Builds the power and log tables of GF(2^m) and answers lookups against them, one word at a
// time. A build word first clears the log store, one entry a cycle over all 2^m entries, then
// walks the LFSR through the 2^m - 1 powers, writing one power and one log entry per cycle; the
// single write port of each store sets this pace. A power or log lookup reads the stores,
// whose read port is registered. A finished result waits in the output register while the next
// word is taken. A write to a defined configuration register marks the tables as not ready until
// the next build.
module gf2m_log_antilog_table_builder_core (
  input  logic                            clk,
  input  logic                            rst_n,
  gla_in_if.sink                          in_ch,
  gla_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [gla_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gla_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int BIT_W = $clog2(gla_pkg::DATA_W);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CLEAR = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;
  localparam logic [1:0] ST_RESP  = 2'd3;

  // Control registers.
  logic [1:0]                 state_r, state_nxt;
  logic [gla_pkg::DEG_W-1:0]  degree_r, degree_nxt;
  logic                       use_custom_r, use_custom_nxt;
  logic [gla_pkg::DATA_W-1:0] custom_poly_r, custom_poly_nxt;
  logic                       built_r, built_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [gla_pkg::ADDR_W-1:0] idx_r, idx_nxt;

  // Payload registers.
  logic [gla_pkg::DATA_W-1:0] lfsr_r, lfsr_nxt;
  logic [7:0]                 opnd_r, opnd_nxt;
  logic                       pwr_sel_r, pwr_sel_nxt;
  logic                       log_sel_r, log_sel_nxt;
  logic                       lz_r, lz_nxt;
  logic                       oor_r, oor_nxt;
  logic [gla_pkg::DATA_W-1:0] res_value_r, res_value_nxt;
  logic                       res_lz_r, res_lz_nxt;
  logic                       res_oor_r, res_oor_nxt;
  logic                       res_ready_r, res_ready_nxt;

  logic [gla_pkg::DEG_W-1:0]  m;
  logic [gla_pkg::DATA_W-1:0] full;
  logic [gla_pkg::DATA_W-1:0] taps;
  logic [gla_pkg::DATA_W-1:0] lfsr_shift;
  logic                       lfsr_top;
  logic                       in_acc;
  logic                       out_free;
  logic [gla_pkg::ADDR_W-1:0] rd_addr;
  logic [gla_pkg::DATA_W-1:0] pwr_rdata;
  logic [gla_pkg::DATA_W-1:0] log_rdata;
  gla_pkg::gla_wr_t           wr;

  // Active degree, field mask and feedback taps.
  always_comb begin
    if (degree_r < gla_pkg::DEG_W'(2)) begin
      m = gla_pkg::DEG_W'(2);
    end else if (degree_r > gla_pkg::DEG_W'(gla_pkg::MAX_DEGREE)) begin
      m = gla_pkg::DEG_W'(gla_pkg::MAX_DEGREE);
    end else begin
      m = degree_r;
    end
    full = {gla_pkg::DATA_W{1'b1}} >> (gla_pkg::DEG_W'(gla_pkg::MAX_DEGREE) - m);
    taps = (use_custom_r ? custom_poly_r : gla_pkg::default_taps(m)) & full;
  end

  // One step of the Galois LFSR.
  assign lfsr_top   = lfsr_r[BIT_W'(m - gla_pkg::DEG_W'(1))];
  assign lfsr_shift = {lfsr_r[gla_pkg::DATA_W-2:0], 1'b0} & full;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign rd_addr     = (state_r == ST_IDLE) ? in_ch.operand : opnd_r;

  // Sequencer, configuration and output register.
  always_comb begin
    state_nxt       = state_r;
    degree_nxt      = degree_r;
    use_custom_nxt  = use_custom_r;
    custom_poly_nxt = custom_poly_r;
    built_nxt       = built_r;
    out_valid_nxt   = out_valid_r;
    idx_nxt         = idx_r;
    lfsr_nxt        = lfsr_r;
    opnd_nxt        = opnd_r;
    pwr_sel_nxt     = pwr_sel_r;
    log_sel_nxt     = log_sel_r;
    lz_nxt          = lz_r;
    oor_nxt         = oor_r;
    res_value_nxt   = res_value_r;
    res_lz_nxt      = res_lz_r;
    res_oor_nxt     = res_oor_r;
    res_ready_nxt   = res_ready_r;
    wr              = '0;

    // Configuration writes; an index past the list is ignored.
    if (cfg_we) begin
      unique case (cfg_index)
        gla_pkg::CFG_DEGREE: begin
          degree_nxt = cfg_wdata[gla_pkg::DEG_W-1:0];
          built_nxt  = 1'b0;
        end
        gla_pkg::CFG_USE_CUSTOM: begin
          use_custom_nxt = cfg_wdata[0];
          built_nxt      = 1'b0;
        end
        gla_pkg::CFG_CUSTOM_POLY: begin
          custom_poly_nxt = gla_pkg::DATA_W'(cfg_wdata);
          built_nxt       = 1'b0;
        end
        default: begin
        end
      endcase
    end

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          opnd_nxt    = in_ch.operand;
          pwr_sel_nxt = 1'b0;
          log_sel_nxt = 1'b0;
          lz_nxt      = 1'b0;
          oor_nxt     = 1'b0;
          state_nxt   = ST_RESP;
          unique case (in_ch.cmd)
            gla_pkg::CMD_BUILD: begin
              idx_nxt   = '0;
              state_nxt = ST_CLEAR;
            end
            gla_pkg::CMD_POWER: begin
              if (in_ch.operand >= full) begin
                oor_nxt = 1'b1;
              end else begin
                pwr_sel_nxt = built_r;
              end
            end
            gla_pkg::CMD_LOG: begin
              if (in_ch.operand > full) begin
                oor_nxt = 1'b1;
              end else if (in_ch.operand == 8'd0) begin
                lz_nxt = 1'b1;
              end else begin
                log_sel_nxt = built_r;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Zero every log entry of the field before the walk.
      ST_CLEAR: begin
        wr.log_we   = 1'b1;
        wr.log_addr = idx_r;
        wr.log_data = '0;
        if (idx_r == full) begin
          idx_nxt   = '0;
          lfsr_nxt  = gla_pkg::DATA_W'(1);
          state_nxt = ST_WALK;
        end else begin
          idx_nxt = idx_r + gla_pkg::ADDR_W'(1);
        end
      end

      // Write alpha^i and its log, then advance the LFSR.
      ST_WALK: begin
        wr.pwr_we   = 1'b1;
        wr.pwr_addr = idx_r;
        wr.pwr_data = lfsr_r;
        wr.log_we   = 1'b1;
        wr.log_addr = lfsr_r;
        wr.log_data = idx_r;
        lfsr_nxt    = lfsr_top ? (lfsr_shift ^ taps) : lfsr_shift;
        if (idx_r == full - gla_pkg::DATA_W'(1)) begin
          built_nxt = 1'b1;
          state_nxt = ST_RESP;
        end else begin
          idx_nxt = idx_r + gla_pkg::ADDR_W'(1);
        end
      end

      // Load the result word once the output register is free.
      ST_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (pwr_sel_r) begin
            res_value_nxt = pwr_rdata;
          end else if (log_sel_r) begin
            res_value_nxt = log_rdata;
          end else begin
            res_value_nxt = '0;
          end
          res_lz_nxt    = lz_r;
          res_oor_nxt   = oor_r;
          res_ready_nxt = built_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      degree_r      <= gla_pkg::DEG_W'(gla_pkg::MAX_DEGREE);
      use_custom_r  <= 1'b0;
      custom_poly_r <= '0;
      built_r       <= 1'b0;
      out_valid_r   <= 1'b0;
      idx_r         <= '0;
    end else begin
      state_r       <= state_nxt;
      degree_r      <= degree_nxt;
      use_custom_r  <= use_custom_nxt;
      custom_poly_r <= custom_poly_nxt;
      built_r       <= built_nxt;
      out_valid_r   <= out_valid_nxt;
      idx_r         <= idx_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    lfsr_r      <= lfsr_nxt;
    opnd_r      <= opnd_nxt;
    pwr_sel_r   <= pwr_sel_nxt;
    log_sel_r   <= log_sel_nxt;
    lz_r        <= lz_nxt;
    oor_r       <= oor_nxt;
    res_value_r <= res_value_nxt;
    res_lz_r    <= res_lz_nxt;
    res_oor_r   <= res_oor_nxt;
    res_ready_r <= res_ready_nxt;
  end

  gla_stores u_stores (
    .clk       (clk),
    .wr        (wr),
    .rd_addr   (rd_addr),
    .pwr_rdata (pwr_rdata),
    .log_rdata (log_rdata)
  );

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = res_value_r;
  assign out_ch.log_of_zero  = res_lz_r;
  assign out_ch.out_of_range = res_oor_r;
  assign out_ch.tables_ready = res_ready_r;

endmodule

/* bench/tb_gf2m_log_antilog_table_builder_core.sv */
module tb_gf2m_log_antilog_table_builder_core;
  timeunit 1ns;
  timeprecision 1ps;

  // Codes that the package leaves unnamed.
  localparam logic [gla_pkg::CMD_W-1:0]     CMD_UNUSED = 2'd3;
  localparam logic [gla_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam int RANDOM_WORDS    = 900;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 520;
  // Every word a build at full degree, each behind the longest gaps on both sides, is
  // still far inside this.
  localparam longint LIMIT_NS    = 64'd25_000_000;

  // One result word as the block returns it.
  typedef struct packed {
    logic [gla_pkg::DATA_W-1:0] value;
    logic                       zero_log;
    logic                       range_err;
    logic                       ready;
  } table_word_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                           cfg_we;
  logic [gla_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [gla_pkg::CFG_DATA_W-1:0] cfg_wdata;

  gla_in_if  in_ch ();
  gla_out_if out_ch ();

  gf2m_log_antilog_table_builder_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Shared control of idling and of the long receiver hold-off.
  bit idle_on      = 1'b1;
  bit hold_off_req = 1'b0;
  int bad_words    = 0;

  table_word_t answers_due[$];

  // Private copy of the field configuration and both tables.
  logic [gla_pkg::DEG_W-1:0]  deg_reg;
  logic                       custom_sel;
  logic [gla_pkg::DATA_W-1:0] poly_reg;
  logic [gla_pkg::DATA_W-1:0] power_tbl [gla_pkg::DEPTH];
  logic [gla_pkg::DATA_W-1:0] log_tbl [gla_pkg::DEPTH];
  logic                       tables_built;

  function automatic int unsigned gap_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  // Feedback taps of the primitive polynomial built into the block for each degree.
  function automatic logic [gla_pkg::DATA_W-1:0] builtin_taps(input int unsigned m);
    case (m)
      5:       return 8'h05;
      8:       return 8'h71;
      default: return 8'h03;
    endcase
  endfunction

  // Degrees outside the supported range are pulled to the nearest end.
  function automatic int unsigned clamped_degree();
    if (deg_reg < 2) return 2;
    if (deg_reg > gla_pkg::MAX_DEGREE) return gla_pkg::MAX_DEGREE;
    return 32'(deg_reg);
  endfunction

  function automatic int unsigned field_order();
    return (1 << clamped_degree()) - 1;
  endfunction

  function automatic void reset_tables();
    int unsigned i;
    for (i = 0; i < gla_pkg::DEPTH; i++) begin
      power_tbl[i] = '0;
      log_tbl[i]   = '0;
    end
  endfunction

  // Walk the Galois LFSR from alpha^0 through all 2^m - 1 powers.
  function automatic void rebuild_tables();
    int unsigned full, top, taps, v, i;
    full = field_order();
    top  = 1 << (clamped_degree() - 1);
    taps = 32'(custom_sel ? poly_reg : builtin_taps(clamped_degree())) & full;
    reset_tables();
    v = 1;
    for (i = 0; i < full; i++) begin
      power_tbl[i]    = v[gla_pkg::DATA_W-1:0];
      log_tbl[v[7:0]] = i[gla_pkg::DATA_W-1:0];
      v = (v & top) ? (((v << 1) & full) ^ taps) : ((v << 1) & full);
    end
    tables_built = 1'b1;
  endfunction

  // Expected result of one accepted word; a build also updates the tables.
  function automatic table_word_t field_answer(input logic [gla_pkg::CMD_W-1:0] code,
                                               input logic [7:0] arg);
    table_word_t a;
    int unsigned full;
    a    = '0;
    full = field_order();
    case (code)
      gla_pkg::CMD_BUILD: rebuild_tables();
      gla_pkg::CMD_POWER: begin
        if (arg >= full) a.range_err = 1'b1;
        else if (tables_built) a.value = power_tbl[arg];
      end
      gla_pkg::CMD_LOG: begin
        if (arg > full) a.range_err = 1'b1;
        else if (arg == 0) a.zero_log = 1'b1;
        else if (tables_built) a.value = log_tbl[arg];
      end
      default: ;
    endcase
    a.ready = tables_built;
    return a;
  endfunction

  // Offer one word, possibly after an idle gap, and record its answer once taken.
  task automatic send_word(input logic [gla_pkg::CMD_W-1:0] code, input logic [7:0] arg);
    int unsigned gap;
    gap = (idle_on && $urandom_range(0, 2) == 0) ? gap_len() : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.cmd     <= code;
    in_ch.operand <= arg;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    answers_due.push_back(field_answer(code, arg));
  endtask

  // Stop offering and wait until every expected word has come back.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (answers_due.size() != 0);
  endtask

  // One register write; the enable stays high until cfg_done.
  task automatic cfg_write(input logic [gla_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      gla_pkg::CFG_DEGREE: begin
        deg_reg = data[gla_pkg::DEG_W-1:0];
        tables_built = 1'b0;
      end
      gla_pkg::CFG_USE_CUSTOM:  begin custom_sel = data[0]; tables_built = 1'b0; end
      gla_pkg::CFG_CUSTOM_POLY: begin poly_reg = data; tables_built = 1'b0; end
      default: ;
    endcase
  endtask

  task automatic cfg_done();
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] pick_operand();
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, field_order()));
  endfunction

  // The first build at reset settings, then the table corners and the log of zero.
  task automatic test_reset_build();
    send_word(gla_pkg::CMD_BUILD, 8'h00);
    send_word(gla_pkg::CMD_POWER, 8'd0);
    send_word(gla_pkg::CMD_POWER, 8'd254);
    send_word(gla_pkg::CMD_POWER, 8'd255);
    send_word(gla_pkg::CMD_LOG, 8'd255);
    send_word(gla_pkg::CMD_LOG, 8'd0);
    send_word(gla_pkg::CMD_LOG, 8'd1);
    wait_idle();
  endtask

  // A register write drops the ready flag until the next build; a write to the
  // unused index must leave it alone.
  task automatic test_config_clears_ready();
    cfg_write(gla_pkg::CFG_DEGREE, 8'd3);
    cfg_done();
    send_word(gla_pkg::CMD_POWER, 8'd2);
    send_word(gla_pkg::CMD_LOG, 8'd9);
    send_word(gla_pkg::CMD_LOG, 8'd0);
    send_word(gla_pkg::CMD_BUILD, 8'hFF);
    send_word(gla_pkg::CMD_LOG, 8'd7);
    send_word(CMD_UNUSED, 8'hA5);
    wait_idle();
    cfg_write(CFG_UNUSED, 8'h5A);
    cfg_done();
    send_word(gla_pkg::CMD_POWER, 8'd6);
    wait_idle();
  endtask

  // Degrees below two and above the maximum, upper data bits ignored.
  task automatic test_degree_limits();
    cfg_write(gla_pkg::CFG_DEGREE, 8'hF0);
    cfg_done();
    send_word(gla_pkg::CMD_BUILD, 8'h00);
    send_word(gla_pkg::CMD_POWER, 8'd2);
    send_word(gla_pkg::CMD_POWER, 8'd3);
    send_word(gla_pkg::CMD_LOG, 8'd3);
    wait_idle();
    cfg_write(gla_pkg::CFG_DEGREE, 8'hFF);
    cfg_done();
    send_word(gla_pkg::CMD_BUILD, 8'h00);
    send_word(gla_pkg::CMD_LOG, 8'h80);
    wait_idle();
  endtask

  // Custom polynomial with bits above the degree set, then one that is not primitive,
  // which leaves some log entries unreached.
  task automatic test_custom_polynomial();
    cfg_write(gla_pkg::CFG_USE_CUSTOM, 8'hFF);
    cfg_write(gla_pkg::CFG_CUSTOM_POLY, 8'hF9);
    cfg_write(gla_pkg::CFG_DEGREE, 8'd4);
    cfg_done();
    send_word(gla_pkg::CMD_BUILD, 8'h00);
    send_word(gla_pkg::CMD_LOG, 8'd15);
    send_word(gla_pkg::CMD_POWER, 8'd14);
    wait_idle();
    cfg_write(gla_pkg::CFG_CUSTOM_POLY, 8'h00);
    cfg_done();
    send_word(gla_pkg::CMD_BUILD, 8'h00);
    send_word(gla_pkg::CMD_LOG, 8'd3);
    send_word(gla_pkg::CMD_LOG, 8'd8);
    wait_idle();
    cfg_write(gla_pkg::CFG_USE_CUSTOM, 8'h00);
    cfg_done();
  endtask

  // The receiver holds off for a long stretch while words keep coming, so the block
  // fills up and stalls its input.
  task automatic test_back_pressure();
    cfg_write(gla_pkg::CFG_DEGREE, 8'd5);
    cfg_done();
    send_word(gla_pkg::CMD_BUILD, 8'h00);
    idle_on      = 1'b0;
    hold_off_req = 1'b1;
    repeat (16) begin
      send_word(($urandom_range(0, 1) != 0) ? gla_pkg::CMD_POWER : gla_pkg::CMD_LOG,
                8'($urandom_range(0, 31)));
    end
    wait_idle();
    idle_on = 1'b1;
  endtask

  // Random settings, each followed mostly by a build and a run of lookups.
  task automatic test_random_phases();
    int sent, n, pick;
    logic [7:0] data;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      if ($urandom_range(0, 2) != 0) begin
        data      = 8'($urandom_range(0, 255));
        data[3:0] = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(2, 6))
                                                : 4'($urandom_range(0, 15));
        cfg_write(gla_pkg::CFG_DEGREE, data);
      end
      if ($urandom_range(0, 2) != 0) begin
        cfg_write(gla_pkg::CFG_USE_CUSTOM, 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 2) != 0) begin
        cfg_write(gla_pkg::CFG_CUSTOM_POLY, 8'($urandom_range(0, 255)));
      end
      cfg_done();
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 7) != 0) begin
        send_word(gla_pkg::CMD_BUILD, 8'($urandom_range(0, 255)));
        sent++;
      end
      n = $urandom_range(20, 40);
      repeat (n) begin
        pick = $urandom_range(0, 99);
        if (pick < 3)       send_word(gla_pkg::CMD_BUILD, 8'($urandom_range(0, 255)));
        else if (pick < 50) send_word(gla_pkg::CMD_POWER, pick_operand());
        else if (pick < 95) send_word(gla_pkg::CMD_LOG, pick_operand());
        else                send_word(CMD_UNUSED, 8'($urandom_range(0, 255)));
      end
      sent += n;
      wait_idle();
    end
    idle_on = 1'b1;
  endtask

  // Receiver: random stalls, and one long hold-off on request.
  initial begin
    forever begin
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Compare each result word with the oldest answer still due.
  always @(posedge clk) begin : check_results
    table_word_t due;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (answers_due.size() == 0) begin
        bad_words++;
        if (bad_words <= 10)
          $display("unexpected word: value %0d log_of_zero %0b out_of_range %0b ready %0b",
                   out_ch.result_value, out_ch.log_of_zero, out_ch.out_of_range,
                   out_ch.tables_ready);
      end else begin
        due = answers_due.pop_front();
        if (out_ch.result_value !== due.value || out_ch.log_of_zero !== due.zero_log ||
            out_ch.out_of_range !== due.range_err || out_ch.tables_ready !== due.ready) begin
          bad_words++;
          if (bad_words <= 10)
            $display("word mismatch: expected %0d/%0b/%0b/%0b, got %0d/%0b/%0b/%0b",
                     due.value, due.zero_log, due.range_err, due.ready,
                     out_ch.result_value, out_ch.log_of_zero, out_ch.out_of_range,
                     out_ch.tables_ready);
        end
      end
    end
  end

  // Main sequence.
  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.cmd     <= gla_pkg::CMD_BUILD;
    in_ch.operand <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= gla_pkg::CFG_DEGREE;
    cfg_wdata     <= '0;
    deg_reg       = 4'd8;
    custom_sel    = 1'b0;
    poly_reg      = '0;
    tables_built  = 1'b0;
    reset_tables();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_build();
    test_config_clears_ready();
    test_degree_limits();
    test_custom_polynomial();
    test_back_pressure();
    test_random_phases();

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (bad_words == 0 && answers_due.size() == 0) begin
      $display("gf2m_log_antilog_table_builder_core regression: pass");
    end else begin
      $display("gf2m_log_antilog_table_builder_core regression: fail");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(LIMIT_NS);
    $display("gf2m_log_antilog_table_builder_core regression: fail");
    $finish;
  end

endmodule
